>>> hw/rtl/rsdc_pkg.sv
// Shared constants and request codes for the recent signature dedup cache.
`default_nettype none

package rsdc_pkg;

    localparam int SIG_W            = 64;
    localparam int REQ_W            = 2;
    localparam int CAPACITY_DEFAULT = 64;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

endpackage : rsdc_pkg

`default_nettype wire

>>> hw/rtl/recent_signature_dedup_cache.sv
// Recent signature dedup cache: FIFO-replaced signature table with serial lookup.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one request beat: i_req_type
//   (lookup, insert, clear; code 3 is ignored) and the 64-bit i_signature.
//   Output channel (o_valid / i_ready) returns one beat per request with
//   o_found, which is 1 only for a lookup that matched a valid entry.
//   Insert, clear and the unused code complete at the accepting edge: the
//   result beat shows on the next cycle, so these requests run one per cycle
//   while the receiver keeps up.
//   A lookup walks the valid entries through the single read port of the
//   signature memory, one entry per cycle, with one compare stage behind it.
//   It stops early on the first hit; an empty table answers at once.
//   o_ready is low while a lookup scan runs, and also while a result beat is
//   held and the receiver stalls: the output register holds the beat and its
//   payload until i_ready is seen.
//   Reset clears the write pointer, the fill count and the control state; the
//   memory itself is not swept, since only entries below the fill count are
//   ever read. A clear request works the same way.
`default_nettype none

module recent_signature_dedup_cache #(
    parameter int CAPACITY = rsdc_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [rsdc_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [rsdc_pkg::SIG_W-1:0]  i_signature,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_found
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    // Signature memory: one write port (insert), one registered read port (scan).
    logic [rsdc_pkg::SIG_W-1:0] r_mem [CAPACITY];
    logic [rsdc_pkg::SIG_W-1:0] r_rd_data;

    t_state                     r_state, n_state;
    logic [ADDR_W-1:0]          r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic                       r_rd_vld, n_rd_vld;
    logic [rsdc_pkg::SIG_W-1:0] r_key, n_key;
    logic                       r_out_vld, n_out_vld;
    logic                       r_found, n_found;

    logic in_beat;
    logic wr_en;
    logic rd_en;
    logic hit;

    assign o_ready = (r_state == S_IDLE) && (!r_out_vld || i_ready);
    assign o_valid = r_out_vld;
    assign o_found = r_found;
    assign in_beat = i_valid && o_ready;

    // Read the next entry while the scan index is still below the fill count.
    assign rd_en = (r_state == S_SCAN) && (r_idx != r_fill);
    assign hit   = r_rd_vld && (r_rd_data == r_key);
    assign wr_en = in_beat && (i_req_type == rsdc_pkg::REQ_INSERT);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_signature;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_wr_ptr  = r_wr_ptr;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_key     = r_key;
        n_out_vld = r_out_vld;
        n_found   = r_found;

        // Drop the held beat once the receiver takes it.
        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_found = 1'b0;
                    priority if (i_req_type == rsdc_pkg::REQ_LOOKUP) begin
                        if (r_fill == '0) begin
                            // Empty table never hits: answer at once.
                            n_out_vld = 1'b1;
                        end else begin
                            n_key   = i_signature;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end else if (i_req_type == rsdc_pkg::REQ_INSERT) begin
                        n_wr_ptr  = (r_wr_ptr == ADDR_W'(CAPACITY - 1)) ?
                                    '0 : r_wr_ptr + ADDR_W'(1);
                        if (r_fill != CNT_W'(CAPACITY)) begin
                            n_fill = r_fill + CNT_W'(1);
                        end
                        n_out_vld = 1'b1;
                    end else if (i_req_type == rsdc_pkg::REQ_CLEAR) begin
                        n_wr_ptr  = '0;
                        n_fill    = '0;
                        n_out_vld = 1'b1;
                    end else begin
                        // Unused code: no state change, plain zero result.
                        n_out_vld = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                // Finish on the first hit, or once every issued read was compared.
                if (hit || (!rd_en && !r_rd_vld)) begin
                    n_rd_vld  = 1'b0;
                    n_found   = hit;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_key   <= n_key;
        r_found <= n_found;
    end

endmodule : recent_signature_dedup_cache

`default_nettype wire

>>> hw/rtl/rsdc_checker.sv
// Port-level checker for the recent signature dedup cache, with its bind.
`default_nettype none

module rsdc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_ready,
    input wire logic [rsdc_pkg::REQ_W-1:0]  i_req_type,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic                        o_found
);

    logic in_beat;
    assign in_beat = i_valid && o_ready;

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat pending after reset");

    // A stalled result beat holds with its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found))
        else $error("stalled result beat changed");

    // Non-lookup requests answer on the next cycle with found clear.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_req_type != rsdc_pkg::REQ_LOOKUP) |=> o_valid && !o_found)
        else $error("non-lookup request result wrong or late");

    // After a lookup is accepted, new requests are blocked until its result beat shows.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_req_type == rsdc_pkg::REQ_LOOKUP) |=> !o_ready || o_valid)
        else $error("request accepted during lookup");

    // A clear followed at once by a lookup must miss.
    a_clear_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_req_type == rsdc_pkg::REQ_CLEAR) ##1
        in_beat && (i_req_type == rsdc_pkg::REQ_LOOKUP) |=> !o_found)
        else $error("lookup hit on cleared table");

endmodule : rsdc_checker

bind recent_signature_dedup_cache rsdc_checker u_rsdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_req_type  (i_req_type),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_found     (o_found)
);

`default_nettype wire
